// ----- hw/rtl/mlt_pkg.sv -----
package mlt_pkg;

   // Field widths fixed by the interface
   localparam int IDX_W   = 10;
   localparam int COORD_W = 20;
   localparam int SLOPE_W = 22;
   localparam int VALUE_W = 64;
   localparam int CSR_W   = 11;

   // Value of an empty node and of a query that finds no line
   localparam logic [VALUE_W-1:0] SENTINEL = 64'h3f3f_3f3f_3f3f_3f3f;

   // Operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // One stored line of a tree node
   typedef struct packed {
      logic                valid;
      logic [SLOPE_W-1:0]  slope;
      logic [VALUE_W-1:0]  intercept;
   } node_line_type;

   // Write controls shared by the row of level cells
   typedef struct packed {
      logic wr;
      logic clr;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/mlt_level_cell.sv -----
// One tree level: node storage for that level, registered read, and a
// link in the read-data chain (the selected level drives, others forward).
module mlt_level_cell #(
   parameter int LEVEL   = 0,
   parameter int NODE_W  = 11,
   parameter int SWEEP_W = 10,
   parameter int LVL_W   = 4
) (
   input  logic                   clock,
   input  mlt_pkg::cell_ctl_type  ctl,
   input  logic [LVL_W-1:0]       lvl,
   input  logic [NODE_W-1:0]      node,
   input  logic [SWEEP_W-1:0]     sweep,
   input  mlt_pkg::node_line_type wdata,
   input  mlt_pkg::node_line_type chain_in,
   output mlt_pkg::node_line_type chain_out
);

   localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;
   localparam int DEPTH = 1 << AW;

   mlt_pkg::node_line_type mem [DEPTH];
   mlt_pkg::node_line_type rdata_ff;
   logic                   hit;
   logic                   hit_ff;

   assign hit = (lvl == LVL_W'(LEVEL));

   // Clear sweep, node write, registered read
   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         mem[sweep[AW-1:0]] <= '0;
      end else if (ctl.wr && hit) begin
         mem[node[AW-1:0]] <= wdata;
      end
      rdata_ff <= mem[node[AW-1:0]];
      hit_ff   <= hit;
   end

   assign chain_out = hit_ff ? rdata_ff : chain_in;

endmodule

// ----- hw/rtl/min_line_tree_over_points_unit.sv -----
// Lower envelope of lines y = k*x + b over a table of loaded points.
// Input: command style. An item is taken at a clock edge with start high and
// busy low; req_opcode selects load point, clear lines, insert line or query.
// Result: a query returns rsp_min_value for one cycle with rsp_strobe high.
// The receiver cannot stall; nothing is held back.
// Config: csr_points_in_use is written on csr_valid (csr_ready is always 1);
// write it only while idle.
// Sequencing: a load and an out-of-range query leave the block idle (the
// query's result follows in the next cycle). A query steps through Q0, Q1 and
// Q2 at each tree level visited, at most ceil(log2(MAX_POINTS))+1 levels,
// with one node read and one multiply per level. An insert steps through IF0
// to IF3 (4 point/node reads) at each node visited, then through up to three
// line compares in EVAL, only one at a leaf, through the one shared
// multiplier; a normal insert visits one node per level, about 11 levels for
// MAX_POINTS = 1024. Clear lines sweeps all level cells in parallel. After
// reset the same clearing pass runs while busy is high; the point table is
// not cleared.
module min_line_tree_over_points_unit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_opcode,
   input  logic [mlt_pkg::IDX_W-1:0]             req_point_index,
   input  logic [mlt_pkg::COORD_W-1:0]           req_coord,
   input  logic signed [mlt_pkg::SLOPE_W-1:0]    req_slope,
   input  logic signed [mlt_pkg::VALUE_W-1:0]    req_intercept,
   output logic                                  rsp_strobe,
   output logic signed [mlt_pkg::VALUE_W-1:0]    rsp_min_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mlt_pkg::CSR_W-1:0]             csr_points_in_use
);

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int NW     = PW + 1;
   localparam int LEVELS = PW + 1;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int CW     = (PW + 1 > mlt_pkg::CSR_W) ? PW + 1 : mlt_pkg::CSR_W;
   localparam int NODES  = 2 * MAX_POINTS;
   localparam int PROD_W = mlt_pkg::SLOPE_W + mlt_pkg::COORD_W + 1;
   localparam int SW     = mlt_pkg::SLOPE_W;
   localparam int VW     = mlt_pkg::VALUE_W;
   localparam int XW     = mlt_pkg::COORD_W;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_IF0   = 4'd2;
   localparam logic [3:0] ST_IF1   = 4'd3;
   localparam logic [3:0] ST_IF2   = 4'd4;
   localparam logic [3:0] ST_IF3   = 4'd5;
   localparam logic [3:0] ST_EVAL  = 4'd6;
   localparam logic [3:0] ST_Q0    = 4'd7;
   localparam logic [3:0] ST_Q1    = 4'd8;
   localparam logic [3:0] ST_Q2    = 4'd9;

   localparam logic [1:0] SEL_M = 2'd0;
   localparam logic [1:0] SEL_L = 2'd1;
   localparam logic [1:0] SEL_R = 2'd2;

   typedef struct packed {
      logic [NW-1:0]    node;
      logic [PW-1:0]    lo;
      logic [PW-1:0]    hi;
      logic [LVL_W-1:0] lvl;
      logic [SW-1:0]    k;
      logic [VW-1:0]    b;
   } stack_entry_type;

   // Control and work registers
   logic [3:0]              state_ff;
   logic [3:0]              state_in;
   logic [PW-1:0]           sweep_ff;
   logic [NW-1:0]           u_ff;
   logic [LVL_W-1:0]        lvl_ff;
   logic [PW-1:0]           l_ff;
   logic [PW-1:0]           r_ff;
   logic [SW-1:0]           k_ff;
   logic [VW-1:0]           b_ff;
   logic [SW-1:0]           nk_ff;
   logic [VW-1:0]           nb_ff;
   logic [XW-1:0]           xm_ff;
   logic [XW-1:0]           xl_ff;
   logic [XW-1:0]           xr_ff;
   logic [1:0]              sel_ff;
   logic [1:0]              ph_ff;
   logic                    go_left_ff;
   logic signed [PROD_W-1:0] mul_ff;
   logic [VW-1:0]           acc_ff;
   logic [LVL_W-1:0]        sp_ff;
   logic [PW-1:0]           qidx_ff;
   logic                    first_ff;
   logic                    beyond_ff;
   logic [VW-1:0]           res_ff;
   logic                    rsp_strobe_ff;
   logic [VW-1:0]           rsp_value_ff;
   logic [mlt_pkg::CSR_W-1:0] csr_ff;

   stack_entry_type         stack_ff [LEVELS];
   stack_entry_type         top_entry;
   logic [XW-1:0]           pt_mem [MAX_POINTS];
   logic [XW-1:0]           pt_rd_ff;
   logic [PW-1:0]           pt_addr;

   logic                    accept;
   logic [CW-1:0]           csr_ext;
   logic [CW-1:0]           span;
   logic [PW-1:0]           r_top;
   logic [CW-1:0]           idx_ext;
   logic [PW-1:0]           mid;
   logic [NW:0]             child_l;
   logic [NW:0]             child_r;
   logic                    child_l_ok;
   logic                    child_r_ok;
   logic [XW-1:0]           x_cur;
   logic [SW-1:0]           mul_k;
   logic [XW-1:0]           mul_x;
   logic signed [PROD_W-1:0] mul_in;
   logic [VW-1:0]           line_val;
   logic                    lt;
   logic                    want_l;
   logic                    want_r;
   logic                    at_end;
   logic [VW-1:0]           q_res;
   logic [VW-1:0]           q_res_sent;

   mlt_pkg::cell_ctl_type   cell_ctl;
   mlt_pkg::node_line_type  cell_wdata;
   mlt_pkg::node_line_type  chain [LEVELS+1];
   mlt_pkg::node_line_type  node_rd;

   function automatic logic [VW-1:0] keep_min(input logic [VW-1:0] res,
                                               input logic [VW-1:0] v,
                                               input logic first);
      if (first || ($signed(v) < $signed(res))) begin
         return v;
      end
      return res;
   endfunction

   // Handshake and span
   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign csr_ext   = CW'(csr_ff);
   assign span      = (csr_ext == '0) ? CW'(1) :
                      (csr_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : csr_ext;
   assign r_top     = PW'(span - CW'(1));
   assign idx_ext   = CW'(req_point_index);

   // Node geometry
   assign mid        = PW'(({1'b0, l_ff} + {1'b0, r_ff}) >> 1);
   assign child_l    = {u_ff, 1'b0};
   assign child_r    = {u_ff, 1'b1};
   assign child_l_ok = (child_l < (NW+1)'(NODES));
   assign child_r_ok = (child_r < (NW+1)'(NODES));
   assign top_entry  = stack_ff[sp_ff - LVL_W'(1)];

   // Point table read address
   always_comb begin
      unique case (state_ff)
         ST_IF1:  pt_addr = l_ff;
         ST_IF2:  pt_addr = r_ff;
         ST_Q0:   pt_addr = qidx_ff;
         default: pt_addr = mid;
      endcase
   end

   // Shared multiplier operand select
   always_comb begin
      unique case (sel_ff)
         SEL_L:   x_cur = xl_ff;
         SEL_R:   x_cur = xr_ff;
         default: x_cur = xm_ff;
      endcase
      if (state_ff == ST_Q1) begin
         mul_k = node_rd.slope;
         mul_x = pt_rd_ff;
      end else if (ph_ff == 2'd0) begin
         mul_k = k_ff;
         mul_x = x_cur;
      end else begin
         mul_k = nk_ff;
         mul_x = x_cur;
      end
   end

   assign mul_in   = $signed(mul_k) * $signed({1'b0, mul_x});
   assign line_val = VW'(mul_ff) + nb_ff;
   assign lt       = $signed(acc_ff) < $signed(line_val);

   // End-of-node routing
   assign at_end = (state_ff == ST_EVAL) && (ph_ff == 2'd2) &&
                   ((sel_ff == SEL_R) || ((sel_ff == SEL_M) && (l_ff >= r_ff)));
   assign want_l = (sel_ff == SEL_R) && go_left_ff && child_l_ok;
   assign want_r = (sel_ff == SEL_R) && lt && child_r_ok;

   // Query combine
   assign q_res      = keep_min(res_ff, line_val, first_ff);
   assign q_res_sent = keep_min(res_ff, mlt_pkg::SENTINEL, first_ff);

   // Level cell controls
   always_comb begin
      cell_ctl.clr = (state_ff == ST_CLEAR);
      cell_ctl.wr  = (state_ff == ST_EVAL) && (sel_ff == SEL_M) && (ph_ff == 2'd2);
      cell_wdata.valid     = 1'b1;
      cell_wdata.slope     = lt ? k_ff : nk_ff;
      cell_wdata.intercept = lt ? b_ff : nb_ff;
   end

   // Row of level cells
   assign chain[0] = '0;
   for (genvar d = 0; d < LEVELS; d++) begin : g_level
      mlt_level_cell #(
         .LEVEL   (d),
         .NODE_W  (NW),
         .SWEEP_W (PW),
         .LVL_W   (LVL_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .lvl       (lvl_ff),
         .node      (u_ff),
         .sweep     (sweep_ff),
         .wdata     (cell_wdata),
         .chain_in  (chain[d]),
         .chain_out (chain[d+1])
      );
   end
   assign node_rd = chain[LEVELS];

   // Point table
   always_ff @(posedge clock) begin
      if (accept && (req_opcode == mlt_pkg::OP_LOAD) && (idx_ext < CW'(MAX_POINTS))) begin
         pt_mem[idx_ext[PW-1:0]] <= req_coord;
      end
      pt_rd_ff <= pt_mem[pt_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (sweep_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  mlt_pkg::OP_CLEAR:  state_in = ST_CLEAR;
                  mlt_pkg::OP_INSERT: state_in = ST_IF0;
                  mlt_pkg::OP_QUERY:  state_in = (idx_ext >= span) ? ST_IDLE : ST_Q0;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_IF0: state_in = ST_IF1;
         ST_IF1: state_in = ST_IF2;
         ST_IF2: state_in = ST_IF3;
         ST_IF3: state_in = ST_EVAL;
         ST_EVAL: begin
            if (at_end) begin
               state_in = (want_l || want_r || (sp_ff != '0)) ? ST_IF0 : ST_IDLE;
            end
         end
         ST_Q0: state_in = ST_Q1;
         ST_Q1: state_in = (beyond_ff || !node_rd.valid) ? ST_IDLE : ST_Q2;
         ST_Q2: state_in = (l_ff >= r_ff) ? ST_IDLE : ST_Q0;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         sp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
         csr_ff        <= mlt_pkg::CSR_W'(1);
      end else begin
         state_ff      <= state_in;
         // Result strobe: out-of-range query, empty or missing node, or last level
         rsp_strobe_ff <= (accept && (req_opcode == mlt_pkg::OP_QUERY) && (idx_ext >= span)) ||
                          ((state_ff == ST_Q1) && (beyond_ff || !node_rd.valid)) ||
                          ((state_ff == ST_Q2) && (l_ff >= r_ff));
         if (csr_valid) begin
            csr_ff <= csr_points_in_use;
         end
         if (state_ff == ST_CLEAR) begin
            sweep_ff <= sweep_ff + PW'(1);
         end
         if (accept && (req_opcode == mlt_pkg::OP_CLEAR)) begin
            sweep_ff <= '0;
         end
         if (accept && (req_opcode == mlt_pkg::OP_INSERT)) begin
            sp_ff <= '0;
         end
         if (at_end) begin
            if (want_l && want_r) begin
               sp_ff <= sp_ff + LVL_W'(1);
            end else if (!want_l && !want_r && (sp_ff != '0)) begin
               sp_ff <= sp_ff - LVL_W'(1);
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (accept) begin
         u_ff      <= NW'(1);
         lvl_ff    <= '0;
         l_ff      <= '0;
         r_ff      <= r_top;
         k_ff      <= req_slope;
         b_ff      <= req_intercept;
         qidx_ff   <= idx_ext[PW-1:0];
         first_ff  <= 1'b1;
         beyond_ff <= 1'b0;
      end
      if (accept && (req_opcode == mlt_pkg::OP_QUERY)) begin
         rsp_value_ff <= mlt_pkg::SENTINEL;
      end

      unique case (state_ff)
         // Fetch node line and the three points
         ST_IF1: begin
            xm_ff <= pt_rd_ff;
            nk_ff <= node_rd.valid ? node_rd.slope : '0;
            nb_ff <= node_rd.valid ? node_rd.intercept : mlt_pkg::SENTINEL;
         end
         ST_IF2: xl_ff <= pt_rd_ff;
         ST_IF3: begin
            xr_ff  <= pt_rd_ff;
            sel_ff <= SEL_M;
            ph_ff  <= 2'd0;
         end
         // Compare both lines at one point, in phases 0, 1 and 2
         ST_EVAL: begin
            if (ph_ff == 2'd0) begin
               ph_ff <= 2'd1;
            end else if (ph_ff == 2'd1) begin
               acc_ff <= VW'(mul_ff) + b_ff;
               ph_ff  <= 2'd2;
            end else begin
               ph_ff <= 2'd0;
               unique case (sel_ff)
                  SEL_M: begin
                     // a leaf carries nothing down, so no swap there
                     if (lt && !at_end) begin
                        nk_ff <= k_ff;
                        nb_ff <= b_ff;
                        k_ff  <= nk_ff;
                        b_ff  <= nb_ff;
                     end
                     sel_ff <= SEL_L;
                  end
                  SEL_L: begin
                     go_left_ff <= lt;
                     sel_ff     <= SEL_R;
                  end
                  default: sel_ff <= SEL_M;
               endcase
               if (at_end) begin
                  if (want_l) begin
                     if (want_r) begin
                        stack_ff[sp_ff] <= '{node: child_r[NW-1:0], lo: mid + PW'(1),
                                             hi: r_ff, lvl: lvl_ff + LVL_W'(1),
                                             k: k_ff, b: b_ff};
                     end
                     u_ff   <= child_l[NW-1:0];
                     r_ff   <= mid;
                     lvl_ff <= lvl_ff + LVL_W'(1);
                  end else if (want_r) begin
                     u_ff   <= child_r[NW-1:0];
                     l_ff   <= mid + PW'(1);
                     lvl_ff <= lvl_ff + LVL_W'(1);
                  end else if (sp_ff != '0) begin
                     u_ff   <= top_entry.node;
                     l_ff   <= top_entry.lo;
                     r_ff   <= top_entry.hi;
                     lvl_ff <= top_entry.lvl;
                     k_ff   <= top_entry.k;
                     b_ff   <= top_entry.b;
                  end
               end
            end
         end
         // Query walk
         ST_Q1: begin
            nb_ff <= node_rd.intercept;
            if (beyond_ff || !node_rd.valid) begin
               rsp_value_ff <= q_res_sent;
            end
         end
         ST_Q2: begin
            res_ff   <= q_res;
            first_ff <= 1'b0;
            if (l_ff >= r_ff) begin
               rsp_value_ff <= q_res;
            end else begin
               lvl_ff <= lvl_ff + LVL_W'(1);
               if (qidx_ff <= mid) begin
                  r_ff <= mid;
                  if (child_l_ok) u_ff <= child_l[NW-1:0];
                  else beyond_ff <= 1'b1;
               end else begin
                  l_ff <= mid + PW'(1);
                  if (child_r_ok) u_ff <= child_r[NW-1:0];
                  else beyond_ff <= 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_min_value = rsp_value_ff;

endmodule

// ----- hw/rtl/mlt_checker.sv -----
// Port-level checks on the command channel and result strobe
module mlt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_opcode,
   input logic       rsp_strobe
);

   // Reset starts the clearing pass and drops any result
   assert property (@(posedge clock) reset |=> busy && !rsp_strobe)
      else $error("reset did not start the clearing pass");

   // An insert walks the tree and never answers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == mlt_pkg::OP_INSERT)) |=> busy && !rsp_strobe)
      else $error("insert did not occupy the block");

   // A clear sweeps the tree and never answers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == mlt_pkg::OP_CLEAR)) |=> busy && !rsp_strobe)
      else $error("clear did not occupy the block");

   // A load leaves the block idle and gives no result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == mlt_pkg::OP_LOAD)) |=> !busy && !rsp_strobe)
      else $error("load took more than one cycle or gave a result");

endmodule

bind min_line_tree_over_points_unit mlt_checker u_mlt_checker (.*);
